### sv/sfs_pkg.sv
`default_nettype none

package sfs_pkg;

    typedef logic [1:0] action_t;

    localparam action_t ACT_TICK  = 2'd0;
    localparam action_t ACT_PLAY  = 2'd1;
    localparam action_t ACT_STOP  = 2'd2;
    localparam action_t ACT_RESET = 2'd3;

    localparam logic REG_FRAME_PERIOD = 1'b0;
    localparam logic REG_FRAME_COUNT  = 1'b1;

    localparam logic [15:0] PERIOD_RESET = 16'd250;
    localparam logic [8:0]  COUNT_RESET  = 9'd1;

    localparam int DIV_W = 18;
    localparam int CNT_W = 5;

    typedef struct packed {
        action_t     action;
        logic [15:0] elapsed;
        logic        loop_mode;
        logic        stop_kind;
    } in_word_t;

    typedef struct packed {
        logic [7:0] frame_index;
        logic       playing;
        logic       looping;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV1,
        ST_DIV2,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic take;
        logic div1_start;
        logic step;
        logic fin1;
        logic fin2;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic over;
        logic loop;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

### sv/sprite_frame_sequencer.sv
// Play, stop, reset and non-advancing ticks go from accept via check straight to output.
// Advancing ticks: play-once mode runs one division, loop mode a second one.
// Advancing ticks are set by one shared 18-step restoring divider (period, then frame wrap).
// The next word is accepted while the previous result waits in the output register.
// aresetn (synchronous, active low) clears index, accumulator and flags, frame_period to 250
// and frame_count to 1.
`default_nettype none

module sprite_frame_sequencer #(
    parameter int MAX_FRAMES = 256
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire sfs_pkg::in_word_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output sfs_pkg::out_word_t     m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [15:0] period_reg;
    logic [8:0]  count_reg;
    logic        wr_en;

    sfs_pkg::cmd_t    cmd;
    sfs_pkg::status_t status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= sfs_pkg::PERIOD_RESET;
            count_reg  <= sfs_pkg::COUNT_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                sfs_pkg::REG_FRAME_PERIOD: period_reg <= pwdata[15:0];
                sfs_pkg::REG_FRAME_COUNT:  count_reg  <= pwdata[8:0];
                default:                   period_reg <= period_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            sfs_pkg::REG_FRAME_PERIOD: prdata = {16'd0, period_reg};
            sfs_pkg::REG_FRAME_COUNT:  prdata = {23'd0, count_reg};
            default:                   prdata = '0;
        endcase
    end

    sfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sfs_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_data       (s_data),
        .frame_period (period_reg),
        .frame_count  (count_reg),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule

`default_nettype wire

### sv/sfs_ctrl.sv
`default_nettype none

module sfs_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire sfs_pkg::status_t status,
    output sfs_pkg::cmd_t         cmd
);

    sfs_pkg::state_t state_reg;
    sfs_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sfs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            sfs_pkg::ST_IDLE: begin
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.take   = 1'b1;
                    state_next = sfs_pkg::ST_CHECK;
                end
            end
            sfs_pkg::ST_CHECK: begin
                if (status.over) begin
                    cmd.div1_start = 1'b1;
                    state_next     = sfs_pkg::ST_DIV1;
                end else begin
                    state_next = sfs_pkg::ST_OUT;
                end
            end
            sfs_pkg::ST_DIV1: begin
                if (status.div_done) begin
                    cmd.fin1   = 1'b1;
                    state_next = status.loop ? sfs_pkg::ST_DIV2 : sfs_pkg::ST_OUT;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            sfs_pkg::ST_DIV2: begin
                if (status.div_done) begin
                    cmd.fin2   = 1'b1;
                    state_next = sfs_pkg::ST_OUT;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            sfs_pkg::ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = sfs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sfs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/sfs_datapath.sv
`default_nettype none

module sfs_datapath #(
    parameter int MAX_FRAMES = 256
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sfs_pkg::in_word_t s_data,
    input  wire logic [15:0]       frame_period,
    input  wire logic [8:0]        frame_count,
    input  wire sfs_pkg::cmd_t     cmd,
    output sfs_pkg::status_t       status,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output sfs_pkg::out_word_t     m_data
);

    localparam int          LIM_INT   = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;
    localparam logic [8:0]  COUNT_LIM = 9'(LIM_INT);

    logic [16:0] accum_reg;
    logic [7:0]  pos_reg;
    logic        run_reg;
    logic        loop_reg;
    logic        tick_go_reg;
    logic        m_valid_reg;
    sfs_pkg::out_word_t out_reg;

    logic [sfs_pkg::DIV_W-1:0] rem_reg;
    logic [sfs_pkg::DIV_W-1:0] quo_reg;
    logic [16:0]               divisor_reg;
    logic [sfs_pkg::CNT_W-1:0] cnt_reg;

    logic [15:0] period_eff;
    logic [8:0]  count_eff;
    logic [8:0]  last;
    logic [8:0]  gap;
    logic [16:0] n_val;
    logic [sfs_pkg::DIV_W-1:0] rem_shift;
    logic [sfs_pkg::DIV_W:0]   diff;
    logic        fits;

    always_comb begin
        period_eff = (frame_period == 16'd0) ? 16'd1 : frame_period;
        if (frame_count == 9'd0) begin
            count_eff = 9'd1;
        end else if (frame_count > COUNT_LIM) begin
            count_eff = COUNT_LIM;
        end else begin
            count_eff = frame_count;
        end
        last      = count_eff - 9'd1;
        gap       = last - {1'b0, pos_reg};
        n_val     = quo_reg[16:0];
        rem_shift = {rem_reg[sfs_pkg::DIV_W-2:0], quo_reg[sfs_pkg::DIV_W-1]};
        diff      = {1'b0, rem_shift} - {2'b00, divisor_reg};
        fits      = !diff[sfs_pkg::DIV_W];
    end

    assign status.over     = tick_go_reg && (accum_reg > {1'b0, period_eff});
    assign status.loop     = loop_reg;
    assign status.div_done = (cnt_reg == '0);
    assign status.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg   <= '0;
            pos_reg     <= '0;
            run_reg     <= 1'b0;
            loop_reg    <= 1'b0;
            tick_go_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            if (cmd.take) begin
                tick_go_reg <= (s_data.action == sfs_pkg::ACT_TICK) && run_reg;
                unique case (s_data.action)
                    sfs_pkg::ACT_TICK: begin
                        if (run_reg) begin
                            accum_reg <= accum_reg + {1'b0, s_data.elapsed};
                        end
                    end
                    sfs_pkg::ACT_PLAY: begin
                        run_reg  <= 1'b1;
                        loop_reg <= s_data.loop_mode;
                    end
                    sfs_pkg::ACT_STOP: begin
                        if (s_data.stop_kind) begin
                            run_reg <= 1'b0;
                        end else begin
                            loop_reg <= 1'b0;
                        end
                    end
                    sfs_pkg::ACT_RESET: begin
                        pos_reg   <= '0;
                        accum_reg <= '0;
                    end
                    default: begin
                        pos_reg <= pos_reg;
                    end
                endcase
            end
            if (cmd.div1_start) begin
                cnt_reg <= sfs_pkg::CNT_W'(sfs_pkg::DIV_W);
            end else if (cmd.step) begin
                cnt_reg <= cnt_reg - sfs_pkg::CNT_W'(1);
            end else if (cmd.fin1 && loop_reg) begin
                cnt_reg <= sfs_pkg::CNT_W'(sfs_pkg::DIV_W);
            end
            if (cmd.fin1) begin
                accum_reg <= rem_reg[16:0] + 17'd1;
                if (!loop_reg) begin
                    if (({1'b0, pos_reg} >= last) || (n_val > {8'd0, gap})) begin
                        pos_reg <= last[7:0];
                        run_reg <= 1'b0;
                    end else begin
                        pos_reg <= pos_reg + n_val[7:0];
                    end
                end
            end
            if (cmd.fin2) begin
                pos_reg <= rem_reg[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div1_start) begin
            rem_reg     <= '0;
            quo_reg     <= {1'b0, accum_reg - 17'd1};
            divisor_reg <= {1'b0, period_eff};
        end else if (cmd.step) begin
            rem_reg <= fits ? diff[sfs_pkg::DIV_W-1:0] : rem_shift;
            quo_reg <= {quo_reg[sfs_pkg::DIV_W-2:0], fits};
        end else if (cmd.fin1) begin
            rem_reg     <= '0;
            quo_reg     <= {10'd0, pos_reg} + {1'b0, n_val};
            divisor_reg <= {8'd0, count_eff};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.frame_index <= pos_reg;
            out_reg.playing     <= run_reg;
            out_reg.looping     <= loop_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire
